// File: rtl/bmrtc_pkg.sv
// ----------------------------------------------------------------------------
// bmrtc_pkg
// Shared types and constants for the bank mapper with real-time clock.
// ----------------------------------------------------------------------------
`default_nettype none

package bmrtc_pkg;

    // Input item operation codes.
    typedef enum logic [2:0] {
        OP_ROM_RD = 3'd0,
        OP_ROM_WR = 3'd1,
        OP_RAM_RD = 3'd2,
        OP_RAM_WR = 3'd3,
        OP_TICK   = 3'd4
    } t_opcode;

    // Result item action codes.
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_FETCH_ROM = 3'd1,
        ACT_READ_RAM  = 3'd2,
        ACT_WRITE_RAM = 3'd3,
        ACT_DIRECT    = 3'd4
    } t_action;

    // Clock register select codes.
    localparam logic [3:0] SEL_SECONDS  = 4'd8;
    localparam logic [3:0] SEL_MINUTES  = 4'd9;
    localparam logic [3:0] SEL_HOURS    = 4'd10;
    localparam logic [3:0] SEL_DAY_LOW  = 4'd11;
    localparam logic [3:0] SEL_DAY_HIGH = 4'd12;

    // ROM write region codes, taken from bus address bits 14:13.
    localparam logic [1:0] REG_RAM_GATE = 2'd0;
    localparam logic [1:0] REG_ROM_BANK = 2'd1;
    localparam logic [1:0] REG_SELECT   = 2'd2;
    localparam logic [1:0] REG_LATCH    = 2'd3;

    localparam int          ADDR_W        = 22;
    localparam logic [7:0]  RAM_GATE_KEY  = 8'h0A;
    localparam logic [7:0]  OPEN_BUS      = 8'hFF;
    localparam logic [7:0]  DAY_HIGH_MASK = 8'hC1;
    localparam logic [7:0]  DAY_HIGH_RST  = 8'h80;
    localparam logic [21:0] ROM_MASK_RST  = 22'h3FFFFF;

    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [7:0] day_low;
        logic [7:0] day_high;
    } t_rtc_time;

    typedef struct packed {
        logic       tick;
        logic       write;
        logic       latch;
        logic [3:0] sel;
        logic [7:0] data;
    } t_rtc_cmd;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] mem_address;
        logic [7:0]        direct_data;
        logic [7:0]        store_byte;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/bmrtc_in_if.sv
// ----------------------------------------------------------------------------
// bmrtc_in_if
// Input channel: one bus access or clock tick per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmrtc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;

    modport source (output valid, output opcode, output bus_address, output write_byte,
                    input ready);
    modport sink   (input valid, input opcode, input bus_address, input write_byte,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/bmrtc_out_if.sv
// ----------------------------------------------------------------------------
// bmrtc_out_if
// Result channel: what the external memory must do for one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmrtc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [21:0] mem_address;
    logic [7:0]  direct_data;
    logic [7:0]  store_byte;

    modport source (output valid, output action, output mem_address, output direct_data,
                    output store_byte, input ready);
    modport sink   (input valid, input action, input mem_address, input direct_data,
                    input store_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/bank_mapper_with_realtime_clock_core.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_realtime_clock_core
// Cartridge bank mapper with real-time clock; one item per cycle if unstalled.
// ----------------------------------------------------------------------------
// The input channel i_in carries one item per handshake: a ROM read or write,
// a RAM read or write, or a clock tick. The result channel o_out returns
// exactly one item for every input item, in order, telling the external
// memory what to do: nothing, fetch ROM, read RAM, write RAM, or take the
// byte returned directly (latched clock data or open bus).
// An accepted item lands in the input register; when it advances, the mapper
// and clock registers are updated and the result is loaded into the output
// register. While the receiver takes results, the block accepts one item per
// cycle: the input register refills in the same cycle its item moves to the
// output register. When the receiver stalls, the held result stays put, the
// input register keeps the next item, and i_in.ready falls only once both
// registers hold items. The ROM address mask is written on i_cfg_we; the user
// must do so only while the block is idle, as the block does not enforce it.
// Reset clears both channels, sets the ROM bank to one, closes the RAM gate,
// zeroes the clock with the day carry set and opens the ROM mask fully.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_with_realtime_clock_core
    import bmrtc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 32,
    parameter int ROM_INDEX_BITS   = 22
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bmrtc_in_if.sink         i_in,
    bmrtc_out_if.source      o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [21:0] i_cfg_wdata
);

    // Result indices are limited to the ROM index width.
    localparam logic [ADDR_W-1:0] ROM_INDEX_MASK =
        ADDR_W'((64'd1 << ROM_INDEX_BITS) - 64'd1);

    logic [21:0] r_rom_mask;

    // Input register.
    logic        r_in_valid;
    logic [2:0]  r_opcode;
    logic [15:0] r_bus_address;
    logic [7:0]  r_write_byte;

    // Output register.
    logic        r_out_valid;
    t_result     r_out;

    logic        w_advance;
    logic        w_in_ready;
    t_rtc_cmd    w_rtc_cmd;
    t_rtc_time   w_held;
    t_result     w_result;
    t_result     w_result_masked;

    // The item in the input register is processed whenever the output
    // register is empty or is being emptied in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_mask <= ROM_MASK_RST;
        end else if (i_cfg_we) begin
            r_rom_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_opcode      <= i_in.opcode;
            r_bus_address <= i_in.bus_address;
            r_write_byte  <= i_in.write_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        w_result_masked             = w_result;
        w_result_masked.mem_address = w_result.mem_address & ROM_INDEX_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result_masked;
        end
    end

    bmrtc_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (w_advance),
        .i_opcode           (r_opcode),
        .i_bus_address      (r_bus_address),
        .i_write_byte       (r_write_byte),
        .i_rom_address_mask (r_rom_mask),
        .i_held             (w_held),
        .o_rtc_cmd          (w_rtc_cmd),
        .o_result           (w_result)
    );

    bmrtc_rtc #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_rtc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_cmd   (w_rtc_cmd),
        .o_held  (w_held)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.action      = r_out.action;
    assign o_out.mem_address = r_out.mem_address;
    assign o_out.direct_data = r_out.direct_data;
    assign o_out.store_byte  = r_out.store_byte;

endmodule

`default_nettype wire

// File: rtl/bmrtc_rtc.sv
// ----------------------------------------------------------------------------
// bmrtc_rtc
// Live and latched clock registers with the tick divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrtc_rtc
    import bmrtc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_rtc_cmd  i_cmd,
    output t_rtc_time      o_held
);

    localparam int PW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [PW-1:0] PHASE_LAST = PW'(TICKS_PER_SECOND - 1);

    logic [PW-1:0] r_phase, n_phase;
    t_rtc_time     r_live, n_live;
    t_rtc_time     r_held, n_held;

    logic [6:0] w_sec1;
    logic [6:0] w_min1;
    logic [5:0] w_hr1;
    logic       w_cs, w_cm, w_ch;
    logic [7:0] w_dh;

    always_comb begin
        n_phase = r_phase;
        n_live  = r_live;
        n_held  = r_held;

        // Second advance: each field wraps within its width, carrying only
        // when it lands exactly on its limit.
        w_sec1 = {1'b0, r_live.seconds} + 7'd1;
        w_cs   = (w_sec1 == 7'd60);
        w_min1 = {1'b0, r_live.minutes} + {6'd0, w_cs};
        w_cm   = (w_min1 == 7'd60);
        w_hr1  = {1'b0, r_live.hours} + {5'd0, w_cm};
        w_ch   = (w_hr1 == 6'd24);
        w_dh   = r_live.day_high ^ 8'h01;

        if (i_cmd.tick) begin
            if (r_phase == PHASE_LAST) begin
                n_phase = '0;
                if (!r_live.day_high[6]) begin
                    n_live.seconds = w_cs ? 6'd0 : w_sec1[5:0];
                    n_live.minutes = w_cm ? 6'd0 : w_min1[5:0];
                    n_live.hours   = w_ch ? 5'd0 : w_hr1[4:0];
                    if (w_ch) begin
                        n_live.day_low = r_live.day_low + 8'd1;
                        if (r_live.day_low == 8'hFF) begin
                            n_live.day_high = w_dh[0] ? w_dh : (w_dh | DAY_HIGH_RST);
                        end
                    end
                end
            end else begin
                n_phase = r_phase + PW'(1);
            end
        end

        if (i_cmd.write) begin
            case (i_cmd.sel)
                SEL_SECONDS:  n_live.seconds  = i_cmd.data[5:0];
                SEL_MINUTES:  n_live.minutes  = i_cmd.data[5:0];
                SEL_HOURS:    n_live.hours    = i_cmd.data[4:0];
                SEL_DAY_LOW:  n_live.day_low  = i_cmd.data;
                SEL_DAY_HIGH: n_live.day_high = i_cmd.data & DAY_HIGH_MASK;
                default: ;
            endcase
        end

        if (i_cmd.latch) begin
            n_held = r_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_live  <= '{seconds: '0, minutes: '0, hours: '0, day_low: '0,
                         day_high: DAY_HIGH_RST};
            r_held  <= '{seconds: '0, minutes: '0, hours: '0, day_low: '0,
                         day_high: DAY_HIGH_RST};
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_live  <= n_live;
            r_held  <= n_held;
        end
    end

    assign o_held = r_held;

endmodule

`default_nettype wire

// File: rtl/bmrtc_ctrl.sv
// ----------------------------------------------------------------------------
// bmrtc_ctrl
// Mapper control registers and the decode of one access into a result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmrtc_ctrl
    import bmrtc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [15:0] i_bus_address,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic [21:0] i_rom_address_mask,
    input  wire t_rtc_time   i_held,
    output t_rtc_cmd         o_rtc_cmd,
    output t_result          o_result
);

    logic [7:0] r_ram_gate, n_ram_gate;
    logic [7:0] r_rom_bank, n_rom_bank;
    logic [3:0] r_select, n_select;
    logic       r_latch_armed, n_latch_armed;

    logic              w_gate_open;
    logic              w_sel_ram;
    logic              w_sel_ok;
    logic [ADDR_W-1:0] w_ram_index;

    always_comb begin
        n_ram_gate    = r_ram_gate;
        n_rom_bank    = r_rom_bank;
        n_select      = r_select;
        n_latch_armed = r_latch_armed;
        o_rtc_cmd     = '0;
        o_rtc_cmd.sel  = r_select;
        o_rtc_cmd.data = i_write_byte;
        o_result      = '0;

        w_gate_open = (r_ram_gate == RAM_GATE_KEY);
        w_sel_ram   = (r_select[3:2] == 2'b00);
        w_sel_ok    = (i_write_byte[7:2] == 6'd0)
                   || ((i_write_byte >= 8'd8) && (i_write_byte <= 8'd12));
        w_ram_index = {7'd0, r_select[1:0], i_bus_address[12:0]};

        unique case (i_opcode)
            OP_ROM_RD: begin
                if (i_bus_address[15]) begin
                    o_result.action      = ACT_DIRECT;
                    o_result.direct_data = OPEN_BUS;
                end else if (!i_bus_address[14]) begin
                    o_result.action      = ACT_FETCH_ROM;
                    o_result.mem_address = {8'd0, i_bus_address[13:0]};
                end else begin
                    o_result.action      = ACT_FETCH_ROM;
                    o_result.mem_address = {r_rom_bank, i_bus_address[13:0]}
                                           & i_rom_address_mask;
                end
            end
            OP_ROM_WR: begin
                if (!i_bus_address[15]) begin
                    unique case (i_bus_address[14:13])
                        REG_RAM_GATE: n_ram_gate = i_write_byte;
                        REG_ROM_BANK: n_rom_bank = (i_write_byte == 8'd0) ? 8'd1
                                                                          : i_write_byte;
                        REG_SELECT: begin
                            if (w_sel_ok) begin
                                n_select = i_write_byte[3:0];
                            end
                        end
                        REG_LATCH: begin
                            o_rtc_cmd.latch = r_latch_armed && (i_write_byte == 8'd1);
                            n_latch_armed   = (i_write_byte == 8'd0);
                        end
                        default: ;
                    endcase
                end
            end
            OP_RAM_RD: begin
                o_result.action = ACT_DIRECT;
                o_result.direct_data = OPEN_BUS;
                if (w_gate_open) begin
                    if (w_sel_ram) begin
                        o_result.action      = ACT_READ_RAM;
                        o_result.mem_address = w_ram_index;
                        o_result.direct_data = 8'd0;
                    end else begin
                        case (r_select)
                            SEL_SECONDS:  o_result.direct_data = {2'd0, i_held.seconds};
                            SEL_MINUTES:  o_result.direct_data = {2'd0, i_held.minutes};
                            SEL_HOURS:    o_result.direct_data = {3'd0, i_held.hours};
                            SEL_DAY_LOW:  o_result.direct_data = i_held.day_low;
                            SEL_DAY_HIGH: o_result.direct_data = i_held.day_high;
                            default:      o_result.direct_data = OPEN_BUS;
                        endcase
                    end
                end
            end
            OP_RAM_WR: begin
                if (w_gate_open) begin
                    if (w_sel_ram) begin
                        o_result.action      = ACT_WRITE_RAM;
                        o_result.mem_address = w_ram_index;
                        o_result.store_byte  = i_write_byte;
                    end else begin
                        o_rtc_cmd.write = 1'b1;
                    end
                end
            end
            OP_TICK: o_rtc_cmd.tick = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_gate    <= '0;
            r_rom_bank    <= 8'd1;
            r_select      <= '0;
            r_latch_armed <= 1'b0;
        end else if (i_fire) begin
            r_ram_gate    <= n_ram_gate;
            r_rom_bank    <= n_rom_bank;
            r_select      <= n_select;
            r_latch_armed <= n_latch_armed;
        end
    end

endmodule

`default_nettype wire

// File: dv/bank_mapper_with_realtime_clock_core_tb.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_realtime_clock_core_tb
// Self-checking testbench for the bank mapper with real-time clock. A directed
// table covers the mapping corners, the latch and the clock rollover, and then
// random bus traffic runs under several ROM mask settings. Every result item
// is checked against a built-in mapper and clock model or a table value.
// ----------------------------------------------------------------------------

module bank_mapper_with_realtime_clock_core_tb;
    import bmrtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The model runs with the same parameters that the block is built with.
    localparam int TICKS_PER_SECOND = 32;
    localparam int ROM_INDEX_BITS   = 22;

    // Result indices are limited to the ROM index width.
    localparam logic [21:0] ROM_INDEX_MASK = 22'((64'd1 << ROM_INDEX_BITS) - 64'd1);

    // A run is declared hung after this many cycles in which neither channel
    // moves an item. The longest legal quiet stretch is the forced receiver
    // hold-off below, so this leaves a wide margin.
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN  = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int PHASE_ITEMS   = 200;

    // Bytes with a meaning of their own on the bus.
    localparam logic [7:0] RAM_BANK_LAST   = 8'd3;
    localparam logic [7:0] LATCH_ARM_BYTE  = 8'h00;
    localparam logic [7:0] LATCH_FIRE_BYTE = 8'h01;
    localparam logic [7:0] HALT_BIT        = 8'h40;
    localparam logic [7:0] DAY_CARRY_BIT   = 8'h80;

    // Opcodes that the block does not decode; they must do nothing.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam t_result NONE_RESULT =
        '{action: ACT_NONE, mem_address: '0, direct_data: '0, store_byte: '0};
    localparam t_result OPEN_BUS_RESULT =
        '{action: ACT_DIRECT, mem_address: '0, direct_data: OPEN_BUS, store_byte: '0};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [21:0] i_cfg_wdata;

    bmrtc_in_if  in_if ();
    bmrtc_out_if out_if ();

    bank_mapper_with_realtime_clock_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .ROM_INDEX_BITS  (ROM_INDEX_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mapper and clock model state. It mirrors what the block holds and is
    // advanced once per accepted input item, in acceptance order.
    // ------------------------------------------------------------------------
    logic [21:0] rom_mask_q;
    logic [7:0]  gate_q;
    logic [7:0]  bank_q;
    logic [3:0]  select_q;
    logic        latch_armed_q;
    int          phase_q;
    t_rtc_time   live_time;
    t_rtc_time   held_time;

    // Results still owed by the block, oldest first.
    t_result expected_actions[$];

    int mismatch_count = 0;
    int accepted_items = 0;
    int quiet_cycles   = 0;

    // Knobs shared by the sender, the receiver and the main sequence.
    bit steady_flow         = 1'b0;
    bit sender_back_to_back = 1'b0;
    int hold_off_len        = 0;

    // One row of the directed table. When typed is set, want is the result
    // read straight off the spec; otherwise the model supplies it.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  reps;
        logic        typed;
        t_result     want;
    } t_dir_row;

    localparam int DIR_ROWS = 36;

    t_dir_row directed_rows [0:DIR_ROWS-1] = '{
        // Fixed ROM region is unbanked; bank one is the reset bank.
        '{OP_ROM_RD, 16'h0000, 8'h00, 8'd1, 1'b1, '{ACT_FETCH_ROM, 22'h000000, 8'h00, 8'h00}},
        '{OP_ROM_RD, 16'h3FFF, 8'h00, 8'd1, 1'b1, '{ACT_FETCH_ROM, 22'h003FFF, 8'h00, 8'h00}},
        '{OP_ROM_RD, 16'h4000, 8'h00, 8'd1, 1'b1, '{ACT_FETCH_ROM, 22'h004000, 8'h00, 8'h00}},
        // A ROM read above the ROM space returns open bus.
        '{OP_ROM_RD, 16'hFFFF, 8'h00, 8'd1, 1'b1, OPEN_BUS_RESULT},
        // RAM gate is closed after reset.
        '{OP_RAM_RD, 16'hA000, 8'h00, 8'd1, 1'b1, OPEN_BUS_RESULT},
        '{OP_RAM_WR, 16'hBFFF, 8'hFF, 8'd1, 1'b1, NONE_RESULT},
        // A ROM write above the ROM space must not open the gate.
        '{OP_ROM_WR, 16'h8000, 8'h0A, 8'd1, 1'b1, NONE_RESULT},
        '{OP_RAM_RD, 16'hA000, 8'h00, 8'd1, 1'b1, OPEN_BUS_RESULT},
        '{OP_ROM_WR, 16'h1FFF, 8'h0A, 8'd1, 1'b1, NONE_RESULT},
        // Bank zero is stored as bank one.
        '{OP_ROM_WR, 16'h3FFF, 8'h00, 8'd1, 1'b1, NONE_RESULT},
        '{OP_ROM_RD, 16'h7FFF, 8'h00, 8'd1, 1'b1, '{ACT_FETCH_ROM, 22'h007FFF, 8'h00, 8'h00}},
        '{OP_ROM_WR, 16'h2000, 8'hFF, 8'd1, 1'b1, NONE_RESULT},
        '{OP_ROM_RD, 16'h4000, 8'h00, 8'd1, 1'b0, NONE_RESULT},
        // A select outside 0-3 and 8-12 is dropped.
        '{OP_ROM_WR, 16'h4000, 8'h0D, 8'd1, 1'b1, NONE_RESULT},
        '{OP_ROM_WR, 16'h5FFF, 8'h03, 8'd1, 1'b1, NONE_RESULT},
        '{OP_RAM_WR, 16'hBFFF, 8'hA5, 8'd1, 1'b0, NONE_RESULT},
        '{OP_RAM_RD, 16'hA000, 8'h00, 8'd1, 1'b0, NONE_RESULT},
        // Set the live clock to the last second of day 511 with the clock
        // halted, so that the halt and the day overflow are both seen.
        '{OP_ROM_WR, 16'h4000, 8'h08, 8'd1, 1'b0, NONE_RESULT},
        '{OP_RAM_WR, 16'hA000, 8'h3B, 8'd1, 1'b0, NONE_RESULT},
        '{OP_ROM_WR, 16'h4000, 8'h09, 8'd1, 1'b0, NONE_RESULT},
        '{OP_RAM_WR, 16'hA000, 8'h3B, 8'd1, 1'b0, NONE_RESULT},
        '{OP_ROM_WR, 16'h4000, 8'h0A, 8'd1, 1'b0, NONE_RESULT},
        '{OP_RAM_WR, 16'hA000, 8'h17, 8'd1, 1'b0, NONE_RESULT},
        '{OP_ROM_WR, 16'h4000, 8'h0B, 8'd1, 1'b0, NONE_RESULT},
        '{OP_RAM_WR, 16'hA000, 8'hFF, 8'd1, 1'b0, NONE_RESULT},
        '{OP_ROM_WR, 16'h4000, 8'h0C, 8'd1, 1'b0, NONE_RESULT},
        '{OP_RAM_WR, 16'hA000, 8'hFF, 8'd1, 1'b0, NONE_RESULT},
        // Half a second halted, then half a second running: the tick phase
        // keeps counting while halted, so the second lands at tick 32.
        '{OP_TICK,   16'h0000, 8'h00, 8'd16, 1'b0, NONE_RESULT},
        '{OP_RAM_WR, 16'hA000, 8'h01, 8'd1, 1'b0, NONE_RESULT},
        '{OP_TICK,   16'hFFFF, 8'hFF, 8'd16, 1'b0, NONE_RESULT},
        // Latch with a 0 then 1 sequence and read back the day high byte.
        '{OP_ROM_WR, 16'h6000, 8'h00, 8'd1, 1'b0, NONE_RESULT},
        '{OP_ROM_WR, 16'h7FFF, 8'h01, 8'd1, 1'b0, NONE_RESULT},
        '{OP_RAM_RD, 16'hA000, 8'h00, 8'd1, 1'b0, NONE_RESULT},
        // Undecoded opcodes do nothing.
        '{OP_SPARE_FIRST,        16'hFFFF, 8'hFF, 8'd1, 1'b1, NONE_RESULT},
        '{OP_SPARE_FIRST + 3'd1, 16'h5555, 8'hAA, 8'd1, 1'b1, NONE_RESULT},
        '{OP_SPARE_LAST,         16'h0000, 8'h00, 8'd1, 1'b1, NONE_RESULT}
    };

    // ------------------------------------------------------------------------
    // Model of the mapper and clock.
    // ------------------------------------------------------------------------
    task automatic reset_mapper_state();
        rom_mask_q    = ROM_MASK_RST;
        gate_q        = '0;
        bank_q        = 8'd1;
        select_q      = '0;
        latch_armed_q = 1'b0;
        phase_q       = 0;
        live_time     = '{seconds: '0, minutes: '0, hours: '0, day_low: '0,
                          day_high: DAY_HIGH_RST};
        held_time     = live_time;
    endtask

    // One second of the live clock. Seconds, minutes and hours only carry
    // when they hit exactly 60, 60 and 24; values written out of range just
    // count on and wrap inside their width. The minute and hour checks run on
    // every second, so a minute written as 60 rolls on the next second.
    function automatic void count_one_second();
        logic [7:0] sec;
        logic [7:0] mins;
        logic [7:0] hrs;
        sec  = {2'b00, live_time.seconds} + 8'd1;
        mins = {2'b00, live_time.minutes};
        hrs  = {3'b000, live_time.hours};
        if (sec == 8'd60) begin
            sec  = '0;
            mins = mins + 8'd1;
        end
        if (mins == 8'd60) begin
            mins = '0;
            hrs  = hrs + 8'd1;
        end
        if (hrs == 8'd24) begin
            hrs = '0;
            live_time.day_low = live_time.day_low + 8'd1;
            // Day counter overflow toggles day bit 8; the carry flag is set
            // when that bit goes back to zero and is never cleared here.
            if (live_time.day_low == 8'd0) begin
                live_time.day_high[0] = ~live_time.day_high[0];
                if (!live_time.day_high[0]) begin
                    live_time.day_high = live_time.day_high | DAY_CARRY_BIT;
                end
            end
        end
        live_time.seconds = sec[5:0];
        live_time.minutes = mins[5:0];
        live_time.hours   = hrs[4:0];
    endfunction

    function automatic void count_tick();
        phase_q = phase_q + 1;
        if (phase_q >= TICKS_PER_SECOND) begin
            phase_q = 0;
        end
        if (phase_q == 0 && (live_time.day_high & HALT_BIT) == 8'd0) begin
            count_one_second();
        end
    endfunction

    function automatic void decode_rom_write(input logic [15:0] addr, input logic [7:0] data);
        if (!addr[15]) begin
            case (addr[14:13])
                REG_RAM_GATE: begin
                    gate_q = data;
                end
                REG_ROM_BANK: begin
                    bank_q = (data == 8'd0) ? 8'd1 : data;
                end
                REG_SELECT: begin
                    if (data <= RAM_BANK_LAST ||
                        (data >= {4'd0, SEL_SECONDS} && data <= {4'd0, SEL_DAY_HIGH})) begin
                        select_q = data[3:0];
                    end
                end
                default: begin
                    if (latch_armed_q && data == LATCH_FIRE_BYTE) begin
                        held_time = live_time;
                    end
                    latch_armed_q = (data == LATCH_ARM_BYTE);
                end
            endcase
        end
    endfunction

    // Work out the result for one access and advance the model state.
    function automatic t_result map_access(input logic [2:0] op, input logic [15:0] addr,
                                           input logic [7:0] data);
        t_result res;
        logic [21:0] ram_index;
        res = NONE_RESULT;
        ram_index = {7'd0, select_q[1:0], addr[12:0]};
        case (op)
            OP_ROM_RD: begin
                if (addr[15]) begin
                    res = OPEN_BUS_RESULT;
                end else if (!addr[14]) begin
                    res.action      = ACT_FETCH_ROM;
                    res.mem_address = {6'd0, addr};
                end else begin
                    res.action      = ACT_FETCH_ROM;
                    res.mem_address = {bank_q, addr[13:0]} & rom_mask_q;
                end
            end
            OP_ROM_WR: begin
                decode_rom_write(addr, data);
            end
            OP_RAM_RD: begin
                if (gate_q != RAM_GATE_KEY) begin
                    res = OPEN_BUS_RESULT;
                end else if ({4'd0, select_q} <= RAM_BANK_LAST) begin
                    res.action      = ACT_READ_RAM;
                    res.mem_address = ram_index;
                end else begin
                    res.action = ACT_DIRECT;
                    case (select_q)
                        SEL_SECONDS:  res.direct_data = {2'b00, held_time.seconds};
                        SEL_MINUTES:  res.direct_data = {2'b00, held_time.minutes};
                        SEL_HOURS:    res.direct_data = {3'b000, held_time.hours};
                        SEL_DAY_LOW:  res.direct_data = held_time.day_low;
                        SEL_DAY_HIGH: res.direct_data = held_time.day_high;
                        default:      res.direct_data = OPEN_BUS;
                    endcase
                end
            end
            OP_RAM_WR: begin
                if (gate_q == RAM_GATE_KEY) begin
                    if ({4'd0, select_q} <= RAM_BANK_LAST) begin
                        res.action      = ACT_WRITE_RAM;
                        res.mem_address = ram_index;
                        res.store_byte  = data;
                    end else begin
                        case (select_q)
                            SEL_SECONDS:  live_time.seconds  = data[5:0];
                            SEL_MINUTES:  live_time.minutes  = data[5:0];
                            SEL_HOURS:    live_time.hours    = data[4:0];
                            SEL_DAY_LOW:  live_time.day_low  = data;
                            SEL_DAY_HIGH: live_time.day_high = data & DAY_HIGH_MASK;
                            default: ;
                        endcase
                    end
                end
            end
            OP_TICK: begin
                count_tick();
            end
            default: ;
        endcase
        res.mem_address = res.mem_address & ROM_INDEX_MASK;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Each item first waits a random number of cycles (none in
    // steady phases or back-to-back bursts), then is held on the bus until the
    // block takes it. The expectation is recorded at the edge where the item is
    // accepted, which keeps the model in step with the block no matter how the
    // sides stall. valid is left high after acceptance so that back-to-back items
    // never drop it; drain_results lowers it when the sender stops.
    // ------------------------------------------------------------------------
    task automatic issue_item(input logic [2:0] op, input logic [15:0] addr,
                              input logic [7:0] data, input logic typed,
                              input t_result want);
        int gap;
        t_result res;
        gap = (steady_flow || sender_back_to_back) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.opcode      <= op;
        in_if.bus_address <= addr;
        in_if.write_byte  <= data;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        res = map_access(op, addr, data);
        expected_actions.push_back(typed ? want : res);
        accepted_items++;
    endtask

    task automatic issue(input logic [2:0] op, input logic [15:0] addr, input logic [7:0] data);
        issue_item(op, addr, data, 1'b0, NONE_RESULT);
    endtask

    // Stop offering items and wait until every owed result has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The mask is only written with the block empty.
    task automatic program_rom_mask(input logic [21:0] mask);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rom_mask_q = mask;
    endtask

    // Address inside one of the four ROM write regions.
    function automatic logic [15:0] region_addr(input logic [1:0] region);
        logic [15:0] r;
        r = 16'($urandom);
        return {1'b0, region, r[12:0]};
    endfunction

    // Address in the external RAM window, now and then anywhere on the bus.
    function automatic logic [15:0] ram_addr();
        logic [15:0] r;
        r = 16'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            return r;
        end
        return {3'b101, r[12:0]};
    endfunction

    task automatic noise_item();
        int pick;
        logic [2:0] op;
        if ($urandom_range(0, 39) == 0) begin
            pick = $urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST);
        end else begin
            pick = $urandom_range(OP_ROM_RD, OP_TICK);
        end
        op = pick[2:0];
        issue(op, 16'($urandom), 8'($urandom));
    endtask

    // Near-rollover values make the carries and the day overflow happen
    // often; the rest are random and include out-of-range clock values.
    function automatic logic [7:0] clock_value(input logic [3:0] sel);
        logic [7:0] r;
        r = 8'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            return r;
        end
        case (sel)
            SEL_SECONDS, SEL_MINUTES: begin
                case ($urandom_range(0, 2))
                    0: return 8'd59;
                    1: return 8'd60;
                    default: return 8'h3F;
                endcase
            end
            SEL_HOURS: return ($urandom_range(0, 1) == 0) ? 8'd23 : 8'h1F;
            SEL_DAY_LOW: return 8'hFF;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 8'h01;
                    1: return 8'h00;
                    2: return 8'h81;
                    default: return 8'h41;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] latch_value();
        logic [7:0] r;
        r = 8'($urandom);
        case ($urandom_range(0, 4))
            0, 1: return LATCH_ARM_BYTE;
            2, 3: return LATCH_FIRE_BYTE;
            default: return r;
        endcase
    endfunction

    // One short, mostly well-formed stretch of bus traffic.
    task automatic random_scene();
        int n;
        logic [7:0] r;
        logic [15:0] a;
        logic [3:0] sel;
        r = 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1: begin
                repeat ($urandom_range(1, 6)) noise_item();
            end
            2, 3: begin
                // Switch the ROM bank and read through both ROM halves.
                issue(OP_ROM_WR, region_addr(REG_ROM_BANK),
                      ($urandom_range(0, 7) == 0) ? 8'h00 : r);
                repeat ($urandom_range(2, 6)) begin
                    a = 16'($urandom);
                    if ($urandom_range(0, 3) != 0) begin
                        a[15:14] = 2'b01;
                    end
                    issue(OP_ROM_RD, a, 8'($urandom));
                end
            end
            4, 5: begin
                // Open the gate, pick a RAM bank and access it.
                issue(OP_ROM_WR, region_addr(REG_RAM_GATE),
                      ($urandom_range(0, 9) == 0) ? r : RAM_GATE_KEY);
                issue(OP_ROM_WR, region_addr(REG_SELECT),
                      ($urandom_range(0, 7) == 0) ? r : 8'($urandom_range(0, 3)));
                repeat ($urandom_range(2, 8)) begin
                    issue(($urandom_range(0, 1) == 0) ? OP_RAM_RD : OP_RAM_WR,
                          ram_addr(), 8'($urandom));
                end
            end
            6: begin
                // Set every clock register, let it run, latch and read back.
                issue(OP_ROM_WR, region_addr(REG_RAM_GATE), RAM_GATE_KEY);
                for (int k = 0; k < 5; k++) begin
                    sel = SEL_SECONDS + k[3:0];
                    issue(OP_ROM_WR, region_addr(REG_SELECT), {4'd0, sel});
                    issue(OP_RAM_WR, ram_addr(), clock_value(sel));
                end
                n = $urandom_range(20, 70);
                repeat (n) issue(OP_TICK, 16'($urandom), 8'($urandom));
                issue(OP_ROM_WR, region_addr(REG_LATCH), LATCH_ARM_BYTE);
                issue(OP_ROM_WR, region_addr(REG_LATCH), LATCH_FIRE_BYTE);
                for (int k = 0; k < 5; k++) begin
                    issue(OP_ROM_WR, region_addr(REG_SELECT), {4'd0, SEL_SECONDS + k[3:0]});
                    issue(OP_RAM_RD, ram_addr(), 8'($urandom));
                end
            end
            7: begin
                // Latch writes of all kinds mixed with ticks and clock reads.
                issue(OP_ROM_WR, region_addr(REG_RAM_GATE), RAM_GATE_KEY);
                issue(OP_ROM_WR, region_addr(REG_SELECT),
                      8'($urandom_range(SEL_SECONDS, SEL_DAY_HIGH)));
                repeat ($urandom_range(4, 8)) begin
                    case ($urandom_range(0, 2))
                        0: issue(OP_ROM_WR, region_addr(REG_LATCH), latch_value());
                        1: repeat ($urandom_range(1, 5)) begin
                            issue(OP_TICK, 16'($urandom), 8'($urandom));
                        end
                        default: issue(OP_RAM_RD, ram_addr(), 8'($urandom));
                    endcase
                end
            end
            default: begin
                // Register writes anywhere on the bus, followed by a read.
                repeat ($urandom_range(2, 6)) begin
                    case ($urandom_range(0, 3))
                        0: r = RAM_GATE_KEY;
                        1: r = 8'h00;
                        2: r = 8'($urandom_range(0, 15));
                        default: r = 8'($urandom);
                    endcase
                    issue(OP_ROM_WR, 16'($urandom), r);
                end
                issue(($urandom_range(0, 1) == 0) ? OP_RAM_RD : OP_ROM_RD,
                      16'($urandom), 8'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result side. The receiver draws a wait before each result item; a long
    // hold-off requested by the main sequence replaces that wait once, which
    // lets both registers of the block fill and its input stall.
    // ------------------------------------------------------------------------
    initial begin : result_receiver
        int stall;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_off_len > 0) begin
                stall = hold_off_len;
                hold_off_len = 0;
            end else if (steady_flow) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_actions.size() == 0) begin
                $error("result item with nothing expected: action %0d", out_if.action);
                mismatch_count++;
            end else begin
                want = expected_actions.pop_front();
                if (out_if.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, out_if.action);
                    mismatch_count++;
                end
                if (out_if.mem_address !== want.mem_address) begin
                    $error("mem_address: expected 0x%06h, got 0x%06h",
                           want.mem_address, out_if.mem_address);
                    mismatch_count++;
                end
                if (out_if.direct_data !== want.direct_data) begin
                    $error("direct_data: expected 0x%02h, got 0x%02h",
                           want.direct_data, out_if.direct_data);
                    mismatch_count++;
                end
                if (out_if.store_byte !== want.store_byte) begin
                    $error("store_byte: expected 0x%02h, got 0x%02h",
                           want.store_byte, out_if.store_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang detector: any handshake on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[bank_mapper_with_realtime_clock_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases, each under
    // its own ROM mask. The second random phase runs with no idling on either
    // side, the third starts with a long receiver hold-off against a sender
    // that never pauses, and the fourth stops the sender halfway until the
    // block has returned everything.
    // ------------------------------------------------------------------------
    initial begin : stimulus_main
        logic [21:0] phase_masks [0:5];
        logic [21:0] r;
        int target;
        bit mid_drained;
        r = 22'($urandom);
        phase_masks = '{ROM_MASK_RST, 22'h000000, 22'h007FFF, 22'h1FFFFF, r, ROM_MASK_RST};
        reset_mapper_state();
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= ROM_MASK_RST;
        in_if.valid       <= 1'b0;
        in_if.opcode      <= OP_ROM_RD;
        in_if.bus_address <= '0;
        in_if.write_byte  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                issue_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                           directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int p = 0; p < 6; p++) begin
            program_rom_mask(phase_masks[p]);
            steady_flow = (p == 1);
            target = accepted_items + PHASE_ITEMS;
            mid_drained = 1'b0;
            if (p == 2) begin
                // Receiver stalls for a long stretch while items keep coming.
                hold_off_len = HOLD_OFF_LEN;
                sender_back_to_back = 1'b1;
                repeat (24) noise_item();
                sender_back_to_back = 1'b0;
            end
            while (accepted_items < target) begin
                if (p == 3 && !mid_drained &&
                    accepted_items >= target - PHASE_ITEMS / 2) begin
                    // Sender pauses until every owed result has come back.
                    drain_results();
                    mid_drained = 1'b1;
                end
                random_scene();
            end
        end
        steady_flow = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_actions.size() != 0) begin
            $error("%0d result items never arrived", expected_actions.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("[bank_mapper_with_realtime_clock_core] OK");
        end else begin
            $display("[bank_mapper_with_realtime_clock_core] ERROR");
        end
        $finish;
    end

endmodule
